/* rtl/gtc_pkg.sv */
// gtc_pkg: shared types, widths, stage map and constant tables for the gamma curve block
// no dependencies; imported by every module under rtl

package gtc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int CH_W        = 16;
    localparam logic [SAMPLE_BITS-1:0] FULL = '1;

    localparam int TH_W       = 16;
    localparam int GL_W       = 24;
    localparam int GC_W       = 24;
    localparam int EX_W       = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KNEE_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CURVE_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CURVE_EXPONENT = 3'd4;

    localparam logic            RST_DIRECTION      = 1'b1;
    localparam logic [TH_W-1:0] RST_KNEE_THRESHOLD = 16'd205;
    localparam logic [GL_W-1:0] RST_LINEAR_GAIN    = 24'd846725;
    localparam logic [GC_W-1:0] RST_CURVE_GAIN     = 24'd69140;
    localparam logic [EX_W-1:0] RST_CURVE_EXPONENT = 20'd27307;

    // log and power datapath widths
    localparam int NUM_W     = GC_W + SAMPLE_BITS + 1;
    localparam int K_W       = $clog2(NUM_W);
    localparam int MANT_W    = 32;
    localparam int FRAC_W    = 32;
    localparam int LOG_W     = K_W + FRAC_W;
    localparam int LO_W      = LOG_W / 2;
    localparam int HI_W      = LOG_W - LO_W;
    localparam int T_W       = EX_W + LOG_W - 16;
    localparam int IP_W      = T_W - FRAC_W;
    localparam int EXP_STEPS = 32;
    localparam int DIV_W     = SAMPLE_BITS + 16;
    localparam int REM_W     = GL_W + 1;
    localparam int Y_W       = GC_W + MANT_W + 2;

    // stage map of one lane
    localparam int LOG_STAGES   = 2 + FRAC_W;
    localparam int STG_LOG0     = 1;
    localparam int STG_DIFF     = STG_LOG0 + LOG_STAGES;
    localparam int STG_MULP     = STG_DIFF + 1;
    localparam int STG_SUM      = STG_MULP + 1;
    localparam int STG_EXP0     = STG_SUM + 1;
    localparam int STG_SHIFT    = STG_EXP0 + EXP_STEPS;
    localparam int STG_PROD     = STG_SHIFT + 1;
    localparam int STG_DIV_DONE = STG_LOG0 + DIV_W;

    typedef struct packed {
        logic [CH_W-1:0] chan0_in;
        logic [CH_W-1:0] chan1_in;
        logic [CH_W-1:0] chan2_in;
    } t_pix_in;

    typedef struct packed {
        logic [CH_W-1:0] chan0_out;
        logic [CH_W-1:0] chan1_out;
        logic [CH_W-1:0] chan2_out;
    } t_pix_out;

    typedef struct packed {
        logic            direction;
        logic [TH_W-1:0] knee_threshold;
        logic [GL_W-1:0] linear_gain;
        logic [GC_W-1:0] curve_gain;
        logic [EX_W-1:0] curve_exponent;
    } t_cfg;

    typedef struct packed {
        logic                   lin;
        logic                   zero;
        logic [SAMPLE_BITS-1:0] samp;
        logic [SAMPLE_BITS-1:0] lin_val;
    } t_side;

    typedef logic [EXP_STEPS-1:0][MANT_W-1:0] t_fac_tab;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] b;
        rem = v;
        res = '0;
        for (int j = 0; j < 32; j++) begin
            b = 64'd1 << (62 - 2 * j);
            if (rem >= res + b) begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
        end
        return res;
    endfunction

    // factors 2^(-2^-i), i = 1..32, Q1.31, by repeated square roots from 0.5
    function automatic t_fac_tab fac_tab();
        t_fac_tab    tab;
        logic [63:0] c;
        c = 64'd1 << 30;
        for (int j = 0; j < EXP_STEPS; j++) begin
            c = isqrt64(c << 31);
            tab[j] = c[MANT_W-1:0];
        end
        return tab;
    endfunction

    localparam t_fac_tab EXP_FAC = fac_tab();

endpackage

/* rtl/gtc_log2.sv */
// gtc_log2: pipelined base-2 logarithm, unsigned Q.32 result
// two normalize stages then one squaring stage per fraction bit; uses gtc_pkg

module gtc_log2
    import gtc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_v,
    output logic [LOG_W-1:0] o_log
);

    logic [NUM_W-1:0]    n_na, r_na, n_nb, r_nb;
    logic [K_W-1:0]      n_sa, r_sa, n_sb, r_sb;
    logic [MANT_W-1:0]   m_in [FRAC_W];
    logic [FRAC_W-1:0]   fr_in [FRAC_W];
    logic [K_W-1:0]      k_in [FRAC_W];
    logic [2*MANT_W-1:0] sq [FRAC_W];
    logic [MANT_W-1:0]   n_m [FRAC_W];
    logic [FRAC_W-1:0]   n_fr [FRAC_W];
    logic [MANT_W-1:0]   r_m [FRAC_W];
    logic [FRAC_W-1:0]   r_fr [FRAC_W];
    logic [K_W-1:0]      r_k [FRAC_W];

    // leading-one search, upper shift steps
    always_comb begin
        n_na = i_v;
        n_sa = '0;
        for (int b = K_W - 1; b >= K_W / 2; b--) begin
            if ((n_na >> (NUM_W - (1 << b))) == '0) begin
                n_na = n_na << (1 << b);
                n_sa = n_sa + K_W'(1 << b);
            end
        end
    end

    // lower shift steps
    always_comb begin
        n_nb = r_na;
        n_sb = r_sa;
        for (int b = K_W / 2 - 1; b >= 0; b--) begin
            if ((n_nb >> (NUM_W - (1 << b))) == '0) begin
                n_nb = n_nb << (1 << b);
                n_sb = n_sb + K_W'(1 << b);
            end
        end
    end

    always_comb begin
        m_in[0]  = r_nb[NUM_W-1 -: MANT_W];
        fr_in[0] = '0;
        k_in[0]  = K_W'(NUM_W - 1) - r_sb;
        for (int j = 1; j < FRAC_W; j++) begin
            m_in[j]  = r_m[j-1];
            fr_in[j] = r_fr[j-1];
            k_in[j]  = r_k[j-1];
        end
        for (int j = 0; j < FRAC_W; j++) begin
            sq[j] = m_in[j] * m_in[j];
            // square reached 2.0: halve and set this fraction bit
            if (sq[j][2*MANT_W-1]) begin
                n_m[j]  = sq[j][2*MANT_W-1 -: MANT_W];
                n_fr[j] = fr_in[j] | (FRAC_W'(1) << (FRAC_W - 1 - j));
            end else begin
                n_m[j]  = sq[j][2*MANT_W-2 -: MANT_W];
                n_fr[j] = fr_in[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_na <= n_na;
            r_sa <= n_sa;
            r_nb <= n_nb;
            r_sb <= n_sb;
            for (int j = 0; j < FRAC_W; j++) begin
                r_m[j]  <= n_m[j];
                r_fr[j] <= n_fr[j];
                r_k[j]  <= k_in[j];
            end
        end
    end

    assign o_log = {r_k[FRAC_W-1], r_fr[FRAC_W-1]};

endmodule

/* rtl/gtc_div.sv */
// gtc_div: pipelined restoring divider for the linear decode segment, one quotient bit a stage
// computes min(FULL, (sample << 16) / gain); uses gtc_pkg

module gtc_div
    import gtc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [SAMPLE_BITS-1:0] i_samp,
    input  logic [GL_W-1:0]        i_gain,
    output logic [SAMPLE_BITS-1:0] o_quo
);

    logic [GL_W-1:0]  g;
    logic [DIV_W-1:0] dd_in [DIV_W];
    logic [DIV_W-1:0] q_in [DIV_W];
    logic [GL_W-1:0]  rem_in [DIV_W];
    logic [REM_W-1:0] rs [DIV_W];
    logic [REM_W-1:0] diff [DIV_W];
    logic [DIV_W-1:0] n_dd [DIV_W];
    logic [DIV_W-1:0] n_q [DIV_W];
    logic [GL_W-1:0]  n_rem [DIV_W];
    logic [DIV_W-1:0] r_dd [DIV_W];
    logic [DIV_W-1:0] r_q [DIV_W];
    logic [GL_W-1:0]  r_rem [DIV_W];

    // zero gain divides by one
    assign g = (i_gain == '0) ? GL_W'(1) : i_gain;

    always_comb begin
        dd_in[0]  = {i_samp, 16'h0};
        q_in[0]   = '0;
        rem_in[0] = '0;
        for (int j = 1; j < DIV_W; j++) begin
            dd_in[j]  = r_dd[j-1];
            q_in[j]   = r_q[j-1];
            rem_in[j] = r_rem[j-1];
        end
        for (int j = 0; j < DIV_W; j++) begin
            rs[j]   = {rem_in[j], dd_in[j][DIV_W-1]};
            diff[j] = rs[j] - {1'b0, g};
            n_dd[j] = dd_in[j] << 1;
            if (rs[j] >= {1'b0, g}) begin
                n_rem[j] = diff[j][GL_W-1:0];
                n_q[j]   = {q_in[j][DIV_W-2:0], 1'b1};
            end else begin
                n_rem[j] = rs[j][GL_W-1:0];
                n_q[j]   = {q_in[j][DIV_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < DIV_W; j++) begin
                r_dd[j]  <= n_dd[j];
                r_q[j]   <= n_q[j];
                r_rem[j] <= n_rem[j];
            end
        end
    end

    assign o_quo = (r_q[DIV_W-1] > DIV_W'(FULL)) ? FULL : r_q[DIV_W-1][SAMPLE_BITS-1:0];

endmodule

/* rtl/gtc_exp2.sv */
// gtc_exp2: pipelined 2^(-f) for the fraction of a Q.32 exponent, Q1.31 mantissa out
// one constant-factor multiply stage per fraction bit; factor table from gtc_pkg

module gtc_exp2
    import gtc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [T_W-1:0]    i_t,
    output logic [MANT_W-1:0] o_p,
    output logic [IP_W-1:0]   o_ip
);

    logic [MANT_W-1:0]   p_in [EXP_STEPS];
    logic [FRAC_W-1:0]   f_in [EXP_STEPS];
    logic [IP_W-1:0]     ip_in [EXP_STEPS];
    logic [2*MANT_W-1:0] prod [EXP_STEPS];
    logic [MANT_W-1:0]   n_p [EXP_STEPS];
    logic [MANT_W-1:0]   r_p [EXP_STEPS];
    logic [FRAC_W-1:0]   r_f [EXP_STEPS];
    logic [IP_W-1:0]     r_ip [EXP_STEPS];

    always_comb begin
        p_in[0]  = MANT_W'(1) << (MANT_W - 1);
        f_in[0]  = i_t[FRAC_W-1:0];
        ip_in[0] = i_t[T_W-1:FRAC_W];
        for (int j = 1; j < EXP_STEPS; j++) begin
            p_in[j]  = r_p[j-1];
            f_in[j]  = r_f[j-1];
            ip_in[j] = r_ip[j-1];
        end
        for (int j = 0; j < EXP_STEPS; j++) begin
            prod[j] = p_in[j] * EXP_FAC[j];
            if (f_in[j][FRAC_W-1-j]) begin
                n_p[j] = prod[j][2*MANT_W-2 -: MANT_W];
            end else begin
                n_p[j] = p_in[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < EXP_STEPS; j++) begin
                r_p[j]  <= n_p[j];
                r_f[j]  <= f_in[j];
                r_ip[j] <= ip_in[j];
            end
        end
    end

    assign o_p  = r_p[EXP_STEPS-1];
    assign o_ip = r_ip[EXP_STEPS-1];

endmodule

/* rtl/gtc_lane.sv */
// gtc_lane: gamma curve for one channel sample, fully pipelined
// uses gtc_pkg, gtc_log2, gtc_div and gtc_exp2

module gtc_lane
    import gtc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_en,
    input  t_cfg            i_cfg,
    input  logic [CH_W-1:0] i_samp,
    output logic [CH_W-1:0] o_res
);

    logic [SAMPLE_BITS-1:0]      samp;
    logic [SAMPLE_BITS+15:0]     in_sh, th_full;
    logic [NUM_W-1:0]            gc_full, n_sum, lim;
    logic                        nonpos;
    logic [NUM_W-1:0]            n_num, n_den, r_num, r_den;
    logic [GL_W+SAMPLE_BITS-1:0] lprod;
    logic [GL_W+SAMPLE_BITS-17:0] lq;
    logic [SAMPLE_BITS-1:0]      quo;
    t_side                       n_side [STG_PROD+1];
    t_side                       r_side [STG_PROD+1];
    logic [LOG_W-1:0]            log_num, log_den;
    logic [LOG_W-1:0]            r_l;
    logic [EX_W+LO_W-1:0]        r_plo;
    logic [EX_W+HI_W-1:0]        r_phi;
    logic [T_W+15:0]             el;
    logic [T_W-1:0]              r_t;
    logic [MANT_W-1:0]           p_mant;
    logic [IP_W-1:0]             p_ip;
    logic [MANT_W-1:0]           n_p, r_p, r_pd;
    logic [GC_W+MANT_W-1:0]      r_prod;
    logic signed [Y_W-1:0]       y;
    logic [46+SAMPLE_BITS:0]     ymul;
    logic [MANT_W+SAMPLE_BITS-1:0] pmul;
    logic [SAMPLE_BITS-1:0]      res_c, res_d, res;

    // entry stage: clamp, knee test and log operands
    always_comb begin
        samp    = (i_samp > CH_W'(FULL)) ? FULL : i_samp[SAMPLE_BITS-1:0];
        in_sh   = {samp, 16'h0};
        th_full = {i_cfg.knee_threshold, {SAMPLE_BITS{1'b0}}}
                  - (SAMPLE_BITS+16)'(i_cfg.knee_threshold);
        gc_full = NUM_W'({i_cfg.curve_gain, {SAMPLE_BITS{1'b0}}})
                  - NUM_W'(i_cfg.curve_gain);
        n_sum   = NUM_W'(in_sh) + gc_full;
        lim     = NUM_W'({FULL, 16'h0});
        nonpos  = n_sum <= lim;
        if (i_cfg.direction) begin
            n_num = NUM_W'(samp);
            n_den = NUM_W'(FULL);
        end else begin
            n_num = n_sum - lim;
            n_den = gc_full;
        end
    end

    assign lprod = r_side[0].samp * i_cfg.linear_gain;
    assign lq    = lprod[GL_W+SAMPLE_BITS-1:16];

    // side line: flags and the linear segment result ride along the log/exp pipe
    always_comb begin
        n_side[0].lin     = in_sh <= th_full;
        n_side[0].zero    = i_cfg.direction ? (samp == '0) : nonpos;
        n_side[0].samp    = samp;
        n_side[0].lin_val = '0;
        for (int s = 1; s <= STG_PROD; s++) begin
            n_side[s] = r_side[s-1];
        end
        n_side[1].lin_val = (lq > (GL_W+SAMPLE_BITS-16)'(FULL)) ? FULL
                                                                : lq[SAMPLE_BITS-1:0];
        if (!i_cfg.direction) begin
            n_side[STG_DIV_DONE].lin_val = quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= n_num;
            r_den <= n_den;
            for (int s = 0; s <= STG_PROD; s++) begin
                r_side[s] <= n_side[s];
            end
        end
    end

    gtc_log2 u_log_num (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_v   (r_num),
        .o_log (log_num)
    );

    gtc_log2 u_log_den (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_v   (r_den),
        .o_log (log_den)
    );

    gtc_div u_div (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_samp (r_side[0].samp),
        .i_gain (i_cfg.linear_gain),
        .o_quo  (quo)
    );

    // exponent e * (log den - log num), split in two partial products
    assign el = {r_phi, {LO_W{1'b0}}} + (T_W+16)'(r_plo);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l   <= (log_den > log_num) ? (log_den - log_num) : '0;
            r_plo <= i_cfg.curve_exponent * r_l[LO_W-1:0];
            r_phi <= i_cfg.curve_exponent * r_l[LOG_W-1:LO_W];
            r_t   <= el[T_W+15:16];
        end
    end

    gtc_exp2 u_exp (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_t   (r_t),
        .o_p   (p_mant),
        .o_ip  (p_ip)
    );

    // integer part of the exponent shifts the mantissa down
    always_comb begin
        if (r_side[STG_SHIFT-1].zero || (p_ip[IP_W-1:5] != '0)) begin
            n_p = '0;
        end else begin
            n_p = p_mant >> p_ip[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p    <= n_p;
            r_prod <= i_cfg.curve_gain * r_p;
            r_pd   <= r_p;
        end
    end

    // output scaling: times FULL as shift and subtract
    always_comb begin
        y = $signed({2'b00, r_prod}) - $signed(Y_W'(i_cfg.curve_gain) << 31)
            + $signed(Y_W'(1) << 47);
        ymul = {y[46:0], {SAMPLE_BITS{1'b0}}} - (47+SAMPLE_BITS)'(y[46:0]);
        if (y <= 0) begin
            res_c = '0;
        end else if (y >= $signed(Y_W'(1) << 47)) begin
            res_c = FULL;
        end else begin
            res_c = ymul[46+SAMPLE_BITS:47];
        end
        pmul = {r_pd, {SAMPLE_BITS{1'b0}}} - (MANT_W+SAMPLE_BITS)'(r_pd);
        if (r_pd >= (MANT_W'(1) << 31)) begin
            res_d = FULL;
        end else begin
            res_d = pmul[30+SAMPLE_BITS:31];
        end
        if (r_side[STG_PROD].lin) begin
            res = r_side[STG_PROD].lin_val;
        end else if (i_cfg.direction) begin
            res = res_c;
        end else begin
            res = res_d;
        end
    end

    assign o_res = CH_W'(res);

endmodule

/* rtl/gamma_transfer_curve.sv */
// gamma_transfer_curve: piecewise gamma encode/decode of a three-channel pixel
// throughput: one pixel per clock while o_stall is low; three identical lanes, each a
// 72-stage pipe set by the 32 log2 squaring stages and 32 power multiply stages; an
// output skid stage follows
// reset (sync, active low) empties the pipe and loads the register defaults
// uses gtc_pkg and gtc_lane

module gamma_transfer_curve
    import gtc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_pix_in               i_word,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_pix_out              o_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg              r_cfg;
    logic [STG_PROD:0] r_vld;
    logic              en;
    logic [CH_W-1:0]   lane_in [3];
    logic [CH_W-1:0]   lane_out [3];
    t_pix_out          merged;
    t_pix_out          n_out, r_out, n_skid, r_skid;
    logic              n_out_vld, r_out_vld, n_skid_full, r_skid_full;
    logic              take, incoming;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.direction      <= RST_DIRECTION;
            r_cfg.knee_threshold <= RST_KNEE_THRESHOLD;
            r_cfg.linear_gain    <= RST_LINEAR_GAIN;
            r_cfg.curve_gain     <= RST_CURVE_GAIN;
            r_cfg.curve_exponent <= RST_CURVE_EXPONENT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DIRECTION:      r_cfg.direction      <= i_cfg_data[0];
                CFG_KNEE_THRESHOLD: r_cfg.knee_threshold <= i_cfg_data[TH_W-1:0];
                CFG_LINEAR_GAIN:    r_cfg.linear_gain    <= i_cfg_data[GL_W-1:0];
                CFG_CURVE_GAIN:     r_cfg.curve_gain     <= i_cfg_data[GC_W-1:0];
                CFG_CURVE_EXPONENT: r_cfg.curve_exponent <= i_cfg_data[EX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // the whole pipe moves unless the skid stage already holds a word
    assign en      = !r_skid_full;
    assign o_stall = r_skid_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[STG_PROD-1:0], i_valid};
        end
    end

    assign lane_in[0] = i_word.chan0_in;
    assign lane_in[1] = i_word.chan1_in;
    assign lane_in[2] = i_word.chan2_in;

    for (genvar c = 0; c < 3; c++) begin : g_lane
        gtc_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_cfg  (r_cfg),
            .i_samp (lane_in[c]),
            .o_res  (lane_out[c])
        );
    end

    assign merged.chan0_out = lane_out[0];
    assign merged.chan1_out = lane_out[1];
    assign merged.chan2_out = lane_out[2];

    assign take     = !r_out_vld || !i_stall;
    assign incoming = en && r_vld[STG_PROD];

    always_comb begin
        n_out       = r_out;
        n_out_vld   = r_out_vld;
        n_skid      = r_skid;
        n_skid_full = r_skid_full;
        if (take) begin
            if (r_skid_full) begin
                n_out       = r_skid;
                n_out_vld   = 1'b1;
                n_skid_full = 1'b0;
            end else begin
                n_out     = merged;
                n_out_vld = incoming;
            end
        end else if (incoming) begin
            n_skid      = merged;
            n_skid_full = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld   <= 1'b0;
            r_skid_full <= 1'b0;
        end else begin
            r_out_vld   <= n_out_vld;
            r_skid_full <= n_skid_full;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid = r_out_vld;
    assign o_word  = r_out;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_full |-> r_out_vld)
        else $error("skid word held without an output word");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_full) |-> $past(r_out_vld && i_stall))
        else $error("skid filled while output was free");

    a_pipe_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_full |=> $stable(r_vld))
        else $error("pipe moved while skid was full");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_stall && !r_skid_full && r_vld[STG_PROD]) |=> r_skid_full)
        else $error("finished word not caught by skid");

endmodule

/* dv/tb_top.sv */
// tb_top: testbench for gamma_transfer_curve, random pixels under random stalls and
// several register settings, each result checked against a local curve predictor
// depends on rtl/gtc_pkg.sv and rtl/gamma_transfer_curve.sv
`timescale 1ns / 100ps

module tb_top;
    import gtc_pkg::*;

    localparam int LATENCY = 72;

    // holds expected pixels and the predictor of the gamma curve
    class gamma_board;
        t_pix_out pending[$];
        int       n_bad;
        logic            dir;
        logic [TH_W-1:0] knee;
        logic [GL_W-1:0] lgain;
        logic [GC_W-1:0] cgain;
        logic [EX_W-1:0] expo;

        function void reset_regs();
            dir = RST_DIRECTION;
            knee = RST_KNEE_THRESHOLD;
            lgain = RST_LINEAR_GAIN;
            cgain = RST_CURVE_GAIN;
            expo = RST_CURVE_EXPONENT;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_DIRECTION:      dir = val[0];
                CFG_KNEE_THRESHOLD: knee = val[TH_W-1:0];
                CFG_LINEAR_GAIN:    lgain = val[GL_W-1:0];
                CFG_CURVE_GAIN:     cgain = val[GC_W-1:0];
                CFG_CURVE_EXPONENT: expo = val[EX_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] log2_fix(logic [63:0] v);
            int          k;
            logic [63:0] m, r;
            k = 63;
            while (k > 0 && !v[k]) k--;
            m = (k >= 31) ? (v >> (k - 31)) : (v << (31 - k));
            r = 64'(k) << 32;
            for (int i = 31; i >= 0; i--) begin
                m = (m * m) >> 31;
                if (m >= (64'd1 << 32)) begin
                    m = m >> 1;
                    r[i] = 1'b1;
                end
            end
            return r;
        endfunction

        function logic [63:0] sqrt_fix(logic [63:0] v);
            logic [63:0] res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        // 2^(-t), t in Q.32, result Q1.31
        function logic [63:0] pow2_neg(logic [63:0] t);
            logic [63:0] p, c;
            p = 64'd1 << 31;
            c = 64'd1 << 30;
            for (int i = 1; i <= 32; i++) begin
                c = sqrt_fix(c << 31);
                if (t[32 - i]) p = (p * c) >> 31;
            end
            if (t[63:32] >= 32) return 0;
            return p >> t[63:32];
        endfunction

        function logic [63:0] ratio_pow(logic [63:0] num, logic [63:0] den);
            logic [63:0] ln, ld, l;
            if (num == 0) return 0;
            ln = log2_fix(num);
            ld = log2_fix(den);
            l = (ld > ln) ? ld - ln : 0;
            return pow2_neg((64'(expo) * l) >> 16);
        endfunction

        function logic [15:0] curve_chan(logic [15:0] s);
            logic [63:0]  x, r, p, n, gc, fullv;
            logic signed [63:0] y;
            x = 64'(s);
            gc = 64'(cgain);
            fullv = 64'(FULL);
            if (x * 65536 <= 64'(knee) * fullv) begin
                if (dir) r = (64'(lgain) * x) >> 16;
                else r = (x * 65536) / (lgain != 0 ? 64'(lgain) : 64'd1);
                return (r > fullv) ? FULL : r[15:0];
            end
            if (dir) begin
                p = ratio_pow(x, fullv);
                y = $signed(gc * p) - $signed(gc << 31) + (64'sd1 <<< 47);
                if (y <= 0) return 0;
                if (y >= (64'sd1 <<< 47)) return FULL;
                r = (64'(y) * fullv) >> 47;
                return r[15:0];
            end
            n = x * 65536 + gc * fullv;
            if (n <= 65536 * fullv) return 0;
            p = ratio_pow(n - 65536 * fullv, fullv * gc);
            if (p >= (64'd1 << 31)) return FULL;
            r = (p * fullv) >> 31;
            return r[15:0];
        endfunction

        function void note_pixel(t_pix_in w);
            t_pix_out e;
            e.chan0_out = curve_chan(w.chan0_in);
            e.chan1_out = curve_chan(w.chan1_in);
            e.chan2_out = curve_chan(w.chan2_in);
            pending = {pending, e};
        endfunction

        function void check_pixel(t_pix_out got);
            t_pix_out e;
            if (pending.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected word %h", got);
                return;
            end
            e = pending.pop_front();
            if (e.chan0_out !== got.chan0_out || e.chan1_out !== got.chan1_out ||
                e.chan2_out !== got.chan2_out) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("mismatch exp %h %h %h got %h %h %h", e.chan0_out,
                             e.chan1_out, e.chan2_out, got.chan0_out, got.chan1_out,
                             got.chan2_out);
            end
        endfunction
    endclass

    logic                  clk = 0;
    logic                  rst_n = 0;
    logic                  in_valid = 0;
    logic                  in_stall;
    t_pix_in               in_word = '0;
    logic                  out_valid;
    logic                  out_stall = 0;
    t_pix_out              out_word;
    logic                  cfg_we = 0;
    logic [CFG_IDX_W-1:0]  cfg_idx = CFG_DIRECTION;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    gamma_board board = new();
    bit quiet = 0;       // no idling and no random receiver stalls in the last part
    int hold_cycles = 0; // long receiver hold-off, counted in the receiver process

    always #5 clk = ~clk;

    gamma_transfer_curve DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall), .i_word(in_word),
        .o_valid(out_valid), .i_stall(out_stall), .o_word(out_word),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) board.note_pixel(in_word);
        if (rst_n && out_valid && !out_stall) board.check_pixel(out_word);
    end

    // receiver stalls
    initial begin
        int run;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                out_stall <= 1;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
                out_stall <= 0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                run = $urandom_range(1, 10);
                out_stall <= 1;
                repeat (run - 1) @(negedge clk);
                @(negedge clk);
                out_stall <= 0;
            end
        end
    end

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'($urandom_range(0, 400));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_pixel(t_pix_in w, bit idle);
        if (idle && !quiet && $urandom_range(0, 7) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        in_valid <= 1;
        in_word <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
        board.write_reg(idx, val);
        @(negedge clk);
    endtask

    task automatic random_pixels(int n);
        t_pix_in w;
        repeat (n) begin
            w.chan0_in = pick_sample();
            w.chan1_in = pick_sample();
            w.chan2_in = pick_sample();
            send_pixel(w, 1);
        end
    endtask

    initial begin
        t_pix_in w;
        board.reset_regs();
        repeat (4) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // directed: extremes around the knee for both directions
        for (int d = 1; d >= 0; d--) begin
            if (d == 0) begin
                drain();
                write_cfg(CFG_DIRECTION, 24'd0);
            end
            w = '{16'h0000, 16'hffff, 16'd205};
            send_pixel(w, 0);
            w = '{16'd204, 16'd206, 16'h8000};
            send_pixel(w, 0);
            w = '{16'h5555, 16'haaaa, 16'd1};
            send_pixel(w, 0);
        end
        drain();
        // degenerate registers: zero gains, zero exponent, full knee
        write_cfg(CFG_LINEAR_GAIN, 24'd0);
        write_cfg(CFG_CURVE_GAIN, 24'd0);
        write_cfg(CFG_CURVE_EXPONENT, 24'd0);
        w = '{16'h0000, 16'hffff, 16'h1234};
        send_pixel(w, 0);
        drain();
        write_cfg(CFG_DIRECTION, 24'd1);
        w = '{16'h0000, 16'hffff, 16'h4321};
        send_pixel(w, 0);
        drain();
        write_cfg(CFG_KNEE_THRESHOLD, 24'hffff);
        write_cfg(CFG_LINEAR_GAIN, 24'hffffff);
        write_cfg(CFG_CURVE_EXPONENT, 24'hfffff);
        w = '{16'h0000, 16'hffff, 16'h7fff};
        send_pixel(w, 0);
        drain();

        // long hold-off while the sender keeps offering
        board.reset_regs();
        write_cfg(CFG_KNEE_THRESHOLD, CFG_DATA_W'(RST_KNEE_THRESHOLD));
        write_cfg(CFG_LINEAR_GAIN, RST_LINEAR_GAIN);
        write_cfg(CFG_CURVE_GAIN, RST_CURVE_GAIN);
        write_cfg(CFG_CURVE_EXPONENT, CFG_DATA_W'(RST_CURVE_EXPONENT));
        hold_cycles = 300;
        random_pixels(150);
        drain();

        // several random settings, extremes among them
        for (int ph = 0; ph < 4; ph++) begin
            write_cfg(CFG_DIRECTION, CFG_DATA_W'(ph[0]));
            write_cfg(CFG_KNEE_THRESHOLD, (ph == 3) ? 24'd0 : 24'($urandom_range(0, 8000)));
            write_cfg(CFG_LINEAR_GAIN, (ph == 2) ? 24'hffffff :
                      24'($urandom_range(1, 16777215)));
            write_cfg(CFG_CURVE_GAIN, (ph == 1) ? 24'hffffff :
                      24'($urandom_range(1, 200000)));
            write_cfg(CFG_CURVE_EXPONENT, (ph == 2) ? 24'hfffff :
                      24'($urandom_range(1, 1048575)));
            random_pixels(100);
            drain();
        end

        // compress with the stock curve, last part without idling
        write_cfg(CFG_DIRECTION, 24'd1);
        write_cfg(CFG_KNEE_THRESHOLD, CFG_DATA_W'(RST_KNEE_THRESHOLD));
        write_cfg(CFG_LINEAR_GAIN, RST_LINEAR_GAIN);
        write_cfg(CFG_CURVE_GAIN, RST_CURVE_GAIN);
        write_cfg(CFG_CURVE_EXPONENT, CFG_DATA_W'(RST_CURVE_EXPONENT));
        random_pixels(60);
        quiet = 1;
        random_pixels(60);
        drain();

        if (board.n_bad == 0 && board.pending.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

/* gamma_transfer_curve.f */
rtl/gtc_pkg.sv
rtl/gtc_log2.sv
rtl/gtc_div.sv
rtl/gtc_exp2.sv
rtl/gtc_lane.sv
rtl/gamma_transfer_curve.sv
dv/tb_top.sv
